/* src/mstk_pkg.sv */
package mstk_pkg;

    localparam int VTX_W     = 5;
    localparam int OUT_WT_W  = 16;
    localparam int RES_DEPTH = 31;
    localparam int RES_AW    = 5;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_SRD   = 14'b00000000000010,
        ST_SKEY  = 14'b00000000000100,
        ST_SCRD  = 14'b00000000001000,
        ST_SCMP  = 14'b00000000010000,
        ST_SPUT  = 14'b00000000100000,
        ST_INIT  = 14'b00000001000000,
        ST_ERD   = 14'b00000010000000,
        ST_ELD   = 14'b00000100000000,
        ST_FRD   = 14'b00001000000000,
        ST_FCHK  = 14'b00010000000000,
        ST_ORD   = 14'b00100000000000,
        ST_OLD   = 14'b01000000000000,
        ST_OWAIT = 14'b10000000000000
    } state_t;

endpackage

/* src/minimum_spanning_tree_kruskal.sv */
// Kruskal minimum spanning tree. Edges stream in one transaction per cycle while
// s_tready is high and are appended to an edge memory; edges naming a vertex at or
// above vertex_count, or arriving when the memory is full, are dropped and flag
// overflow. The transaction with tlast starts the run and the block deasserts s_tready
// until every result has been taken. The run is a stable insertion sort on the edge
// memory, a parent-table initialization over all MAX_VERTICES entries, then for each
// edge two root walks, one parent link at a time, through the parent memory, which
// has one read port and one write port. Tree edges are buffered and emitted in
// ascending weight order, each held until the master takes it; tlast marks the
// final one. An empty tree yields one result with edge_valid clear.
module minimum_spanning_tree_kruskal #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,   // vertex_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // src_vertex[4:0], dst_vertex[9:5], edge_weight[25:10]
    input  logic        s_tlast,       // final_edge
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // tree_src[4:0], tree_dst[9:5], tree_weight[25:10]
    output logic [1:0]  m_tuser,       // edge_valid[0], overflow[1]
    output logic        m_tlast        // last_result
);
    import mstk_pkg::*;

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int PW = $clog2(MAX_VERTICES);
    localparam int EW = 2 * VTX_W + WEIGHT_BITS;
    localparam int RW = 2 * VTX_W + OUT_WT_W;
    localparam logic [6:0]    MAXV    = 7'(MAX_VERTICES);
    localparam logic [CW-1:0] MAXE    = CW'(MAX_EDGES);
    localparam logic [PW-1:0] LAST_PV = PW'(MAX_VERTICES - 1);

    state_t state_reg, state_next;

    logic [5:0]     vcount_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           drop_reg, drop_next;
    logic [CW-1:0]  i_reg, i_next, j_reg, j_next;
    logic [EW-1:0]  key_reg, key_next;
    logic [PW-1:0]  init_reg, init_next;
    logic [VTX_W-1:0] v_reg, v_next, rs_reg, rs_next;
    logic [VTX_W-1:0] cs_reg, cs_next, cd_reg, cd_next;
    logic [WEIGHT_BITS-1:0] cw_reg, cw_next;
    logic           second_reg, second_next;
    logic [RES_AW:0] n_reg, n_next;
    logic [RES_AW-1:0] o_reg, o_next;
    logic           mv_reg, mv_next, ml_reg, ml_next;
    logic [31:0]    md_reg, md_next;
    logic [1:0]     mu_reg, mu_next;

    logic [EW-1:0]  emem [MAX_EDGES];
    logic           e_we;
    logic [AW-1:0]  e_wa, e_ra;
    logic [EW-1:0]  e_wd, e_q;

    logic [VTX_W-1:0] pmem [MAX_VERTICES];
    logic           p_we;
    logic [PW-1:0]  p_wa, p_ra;
    logic [VTX_W-1:0] p_wd, p_q;

    logic [RW-1:0]  rmem [RES_DEPTH];
    logic           r_we;
    logic [RES_AW-1:0] r_wa, r_ra;
    logic [RW-1:0]  r_wd, r_q;

    logic [6:0]     nv;
    logic [VTX_W-1:0] in_src, in_dst, ed_src, ed_dst;
    logic [WEIGHT_BITS-1:0] in_wt;
    logic           in_bad;

    assign nv     = ({1'b0, vcount_reg} > MAXV) ? MAXV : {1'b0, vcount_reg};
    assign in_src = s_tdata[4:0];
    assign in_dst = s_tdata[9:5];
    assign in_wt  = WEIGHT_BITS'(s_tdata[25:10]);
    assign in_bad = ({2'b0, in_src} >= nv) || ({2'b0, in_dst} >= nv) || (cnt_reg >= MAXE);
    assign ed_src = e_q[VTX_W-1:0];
    assign ed_dst = e_q[2*VTX_W-1:VTX_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

    always_ff @(posedge aclk) begin
        if (e_we) begin
            emem[e_wa] <= e_wd;
        end
        e_q <= emem[e_ra];
        if (p_we) begin
            pmem[p_wa] <= p_wd;
        end
        p_q <= pmem[p_ra];
        if (r_we) begin
            rmem[r_wa] <= r_wd;
        end
        r_q <= rmem[r_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            vcount_reg <= 6'd32;
            cnt_reg    <= '0;
            drop_reg   <= 1'b0;
            n_reg      <= '0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            if (cfg_wr_en) begin
                vcount_reg <= cfg_wr_data;
            end
            cnt_reg    <= cnt_next;
            drop_reg   <= drop_next;
            n_reg      <= n_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        key_reg    <= key_next;
        init_reg   <= init_next;
        v_reg      <= v_next;
        rs_reg     <= rs_next;
        cs_reg     <= cs_next;
        cd_reg     <= cd_next;
        cw_reg     <= cw_next;
        second_reg <= second_next;
        o_reg      <= o_next;
        ml_reg     <= ml_next;
        md_reg     <= md_next;
        mu_reg     <= mu_next;
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        drop_next   = drop_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        key_next    = key_reg;
        init_next   = init_reg;
        v_next      = v_reg;
        rs_next     = rs_reg;
        cs_next     = cs_reg;
        cd_next     = cd_reg;
        cw_next     = cw_reg;
        second_next = second_reg;
        n_next      = n_reg;
        o_next      = o_reg;
        mv_next     = mv_reg;
        ml_next     = ml_reg;
        md_next     = md_reg;
        mu_next     = mu_reg;
        e_we = 1'b0;
        e_wa = cnt_reg[AW-1:0];
        e_wd = {in_wt, in_dst, in_src};
        e_ra = i_reg[AW-1:0];
        p_we = 1'b0;
        p_wa = init_reg;
        p_wd = VTX_W'(init_reg);
        p_ra = PW'(v_reg);
        r_we = 1'b0;
        r_wa = n_reg[RES_AW-1:0];
        r_wd = {OUT_WT_W'(cw_reg), cd_reg, cs_reg};
        r_ra = o_reg;

        case (state_reg)
            ST_IDLE: begin
                init_next = '0;
                if (s_tvalid) begin
                    if (in_bad) begin
                        drop_next = 1'b1;
                    end else begin
                        e_we     = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        i_next = CW'(1);
                        state_next = (cnt_next > CW'(1)) ? ST_SRD : ST_INIT;
                    end
                end
            end
            ST_SRD: begin
                state_next = ST_SKEY;
            end
            ST_SKEY: begin
                key_next   = e_q;
                j_next     = i_reg;
                state_next = ST_SCRD;
            end
            ST_SCRD: begin
                e_ra       = AW'(j_reg - 1'b1);
                state_next = ST_SCMP;
            end
            ST_SCMP: begin
                if (e_q[EW-1:2*VTX_W] > key_reg[EW-1:2*VTX_W]) begin
                    e_we   = 1'b1;
                    e_wa   = j_reg[AW-1:0];
                    e_wd   = e_q;
                    j_next = j_reg - 1'b1;
                    state_next = (j_next == '0) ? ST_SPUT : ST_SCRD;
                end else begin
                    state_next = ST_SPUT;
                end
            end
            ST_SPUT: begin
                e_we   = 1'b1;
                e_wa   = j_reg[AW-1:0];
                e_wd   = key_reg;
                i_next = i_reg + 1'b1;
                state_next = (i_next < cnt_reg) ? ST_SRD : ST_INIT;
            end
            ST_INIT: begin
                p_we = 1'b1;
                i_next = '0;
                init_next = init_reg + 1'b1;
                if (init_reg == LAST_PV) begin
                    state_next = (cnt_reg == '0) ? ST_ORD : ST_ERD;
                end
            end
            ST_ERD: begin
                state_next = ST_ELD;
            end
            ST_ELD: begin
                cs_next     = ed_src;
                cd_next     = ed_dst;
                cw_next     = e_q[EW-1:2*VTX_W];
                v_next      = ed_src;
                second_next = 1'b0;
                if (({2'b0, ed_src} >= nv) || ({2'b0, ed_dst} >= nv)) begin
                    drop_next = 1'b1;
                    i_next    = i_reg + 1'b1;
                    state_next = (i_next < cnt_reg) ? ST_ERD : ST_ORD;
                end else begin
                    state_next = ST_FRD;
                end
            end
            ST_FRD: begin
                state_next = ST_FCHK;
            end
            ST_FCHK: begin
                if (p_q == v_reg) begin
                    if (!second_reg) begin
                        rs_next     = v_reg;
                        v_next      = cd_reg;
                        second_next = 1'b1;
                        state_next  = ST_FRD;
                    end else begin
                        if ((rs_reg != v_reg) && (n_reg < (RES_AW + 1)'(RES_DEPTH))) begin
                            r_we   = 1'b1;
                            n_next = n_reg + 1'b1;
                            p_we   = 1'b1;
                            p_wa   = PW'(rs_reg);
                            p_wd   = v_reg;
                        end
                        o_next = '0;
                        i_next = i_reg + 1'b1;
                        state_next = (i_next < cnt_reg) ? ST_ERD : ST_ORD;
                    end
                end else begin
                    v_next     = p_q;
                    state_next = ST_FRD;
                end
            end
            ST_ORD: begin
                if (n_reg == '0) begin
                    md_next = '0;
                    mu_next = {drop_reg, 1'b0};
                    ml_next = 1'b1;
                    mv_next = 1'b1;
                    state_next = ST_OWAIT;
                end else begin
                    state_next = ST_OLD;
                end
            end
            ST_OLD: begin
                md_next = {{(32 - RW){1'b0}}, r_q};
                mu_next = {drop_reg, 1'b1};
                ml_next = ({1'b0, o_reg} == n_reg - 1'b1);
                mv_next = 1'b1;
                state_next = ST_OWAIT;
            end
            ST_OWAIT: begin
                if (m_tready) begin
                    mv_next = 1'b0;
                    if (ml_reg) begin
                        cnt_next  = '0;
                        drop_next = 1'b0;
                        n_next    = '0;
                        state_next = ST_IDLE;
                    end else begin
                        o_next = o_reg + 1'b1;
                        state_next = ST_ORD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* bench/mstk_checker.sv */
module mstk_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mstk_pkg::*;

    localparam int NVTX  = 32;
    localparam int NEDGE = 256;

    typedef struct packed {
        logic [VTX_W-1:0]    src;
        logic [VTX_W-1:0]    dst;
        logic [OUT_WT_W-1:0] wt;
        logic                valid;
        logic                last;
        logic                ovf;
    } tree_edge_t;

    tree_edge_t       tree_edges_due[$];
    logic [VTX_W-1:0] store_src[NEDGE];
    logic [VTX_W-1:0] store_dst[NEDGE];
    logic [15:0]      store_wt[NEDGE];
    int               store_cnt;
    bit               dropped;
    logic [5:0]       vtx_cnt;

    function automatic int live_vertices();
        return (vtx_cnt > NVTX) ? NVTX : int'(vtx_cnt);
    endfunction

    function automatic int find_root(ref int parent[NVTX], input int v);
        for (int k = 0; k < NVTX; k++) begin
            if (parent[v % NVTX] == v) break;
            v = parent[v % NVTX];
        end
        return v;
    endfunction

    function automatic void build_tree();
        int         parent[NVTX];
        int         nv;
        int         j;
        int         rs;
        int         rd;
        int         n;
        logic [VTX_W-1:0] ts;
        logic [VTX_W-1:0] td;
        logic [15:0] tw;
        tree_edge_t found[$];
        tree_edge_t e;
        nv = live_vertices();
        for (int i = 1; i < store_cnt; i++) begin
            ts = store_src[i];
            td = store_dst[i];
            tw = store_wt[i];
            j = i;
            while (j > 0 && store_wt[j-1] > tw) begin
                store_src[j] = store_src[j-1];
                store_dst[j] = store_dst[j-1];
                store_wt[j]  = store_wt[j-1];
                j--;
            end
            store_src[j] = ts;
            store_dst[j] = td;
            store_wt[j]  = tw;
        end
        for (int i = 0; i < NVTX; i++) parent[i] = i;
        n = 0;
        for (int i = 0; i < store_cnt; i++) begin
            if (store_src[i] >= nv || store_dst[i] >= nv) begin
                dropped = 1'b1;
                continue;
            end
            rs = find_root(parent, store_src[i]);
            rd = find_root(parent, store_dst[i]);
            if (rs != rd && n < RES_DEPTH) begin
                e = '{store_src[i], store_dst[i], store_wt[i], 1'b1, 1'b0, 1'b0};
                found = {found, e};
                n++;
                parent[rs % NVTX] = rd;
            end
        end
        if (n == 0) begin
            e = '{'0, '0, '0, 1'b0, 1'b1, 1'b0};
            found = {found, e};
        end
        found[found.size()-1].last = 1'b1;
        foreach (found[k]) begin
            found[k].ovf = dropped;
            tree_edges_due = {tree_edges_due, found[k]};
        end
        store_cnt = 0;
        dropped   = 1'b0;
    endfunction

    task automatic report(input string what, input int want, input int got);
        $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
    end

    always @(posedge aclk) begin
        tree_edge_t want;
        logic [4:0] s;
        logic [4:0] d;
        if (!aresetn) begin
            store_cnt = 0;
            dropped   = 1'b0;
            vtx_cnt   = 6'd32;
            tree_edges_due.delete();
        end else begin
            if (cfg_wr_en) vtx_cnt = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                s = s_tdata[4:0];
                d = s_tdata[9:5];
                if (s >= live_vertices() || d >= live_vertices() || store_cnt >= NEDGE) begin
                    dropped = 1'b1;
                end else begin
                    store_src[store_cnt] = s;
                    store_dst[store_cnt] = d;
                    store_wt[store_cnt]  = s_tdata[25:10];
                    store_cnt++;
                end
                if (s_tlast) build_tree();
            end
            if (m_tvalid && m_tready) begin
                if (tree_edges_due.size() == 0) begin
                    report("unexpected result", 0, 1);
                end else begin
                    want = tree_edges_due.pop_front();
                    if (m_tdata[4:0] !== want.src)
                        report("tree_src", want.src, m_tdata[4:0]);
                    if (m_tdata[9:5] !== want.dst)
                        report("tree_dst", want.dst, m_tdata[9:5]);
                    if (m_tdata[25:10] !== want.wt)
                        report("tree_weight", want.wt, m_tdata[25:10]);
                    if (m_tuser[0] !== want.valid)
                        report("edge_valid", want.valid, m_tuser[0]);
                    if (m_tuser[1] !== want.ovf)
                        report("overflow", want.ovf, m_tuser[1]);
                    if (m_tlast !== want.last)
                        report("last_result", want.last, m_tlast);
                end
            end
        end
        pending = tree_edges_due.size();
    end

endmodule

/* bench/minimum_spanning_tree_kruskal_tb.sv */
module minimum_spanning_tree_kruskal_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [5:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    bit          hold_req;
    bit          hold_done;
    bit          burst_mode;
    int          nv;
    int          sent;

    minimum_spanning_tree_kruskal DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    mstk_checker u_checker (.*);

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    initial begin
        #60ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic send_edge(input int src, input int dst, input int wt, input bit fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, wt[15:0], dst[4:0], src[4:0]};
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_vertices(input int value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[5:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        nv = (value > 32) ? 32 : value;
    endtask

    function automatic int pick_weight();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 3);
            1: return $urandom_range(65530, 65535);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int pick_vertex();
        if (nv == 0 || $urandom_range(0, 19) == 0) return $urandom_range(0, 31);
        return $urandom_range(0, nv - 1);
    endfunction

    initial begin
        int n;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        burst_mode  = 1'b0;
        nv          = 32;
        sent        = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_edge(0, 31, 16'hFFFF, 0);
        send_edge(31, 0, 0, 0);
        send_edge(5, 5, 7, 0);
        send_edge(1, 2, 3, 0);
        send_edge(2, 3, 3, 0);
        send_edge(1, 3, 3, 0);
        send_edge(3, 4, 100, 1);
        send_edge(7, 7, 9, 1);
        set_vertices(4);
        send_edge(5, 1, 2, 0);
        send_edge(0, 1, 2, 0);
        send_edge(2, 3, 1, 1);
        set_vertices(0);
        send_edge(0, 0, 1, 1);
        set_vertices(63);
        send_edge(30, 31, 21845, 0);
        send_edge(31, 30, 43690, 1);
        set_vertices(32);
        send_edge(20, 21, 5, 0);
        send_edge(0, 1, 6, 0);
        set_vertices(10);
        send_edge(2, 3, 7, 1);

        while (sent < 80) begin
            case ($urandom_range(0, 5))
                0: set_vertices($urandom_range(1, 2));
                1: set_vertices($urandom_range(33, 63));
                2: set_vertices(32);
                default: set_vertices($urandom_range(1, 32));
            endcase
            burst_mode = ($urandom_range(0, 3) == 0);
            if (sent > 40 && !hold_done) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            for (int g = 0; g < 3; g++) begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send_edge(pick_vertex(), pick_vertex(), pick_weight(), i == n - 1);
            end
        end

        set_vertices(32);
        burst_mode = 1'b1;
        for (int i = 0; i < 260; i++)
            send_edge(pick_vertex(), pick_vertex(), pick_weight(), i == 259);
        burst_mode = 1'b0;

        drain_results();
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* minimum_spanning_tree_kruskal.f */
src/mstk_pkg.sv
src/minimum_spanning_tree_kruskal.sv
bench/mstk_checker.sv
bench/minimum_spanning_tree_kruskal_tb.sv
